>>> hdl/deq_pkg.sv
// Shared constants, types and helpers of the double-ended queue.
package deq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_PUSH_FULL  = 2'd1,
    STAT_POP_EMPTY  = 2'd2
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;

  // Per-cell command for one update cycle.
  typedef struct packed {
    logic shift_up;    // take the word of the cell nearer the front
    logic shift_down;  // take the word of the cell nearer the back
    logic load;        // take the pushed word
  } cell_ctrl_t;

  // Sign-extend (or truncate) a stored word to the 32-bit result width.
  function automatic logic [VAL_W-1:0] word_out(input word_t w);
    logic signed [WORD_BITS-1:0] ws;
    logic signed [63:0]          wide;
    ws   = $signed(w);
    wide = 64'(ws);
    return wide[VAL_W-1:0];
  endfunction

  // Bring a 32-bit signed input to the stored word width.
  function automatic word_t word_in(input logic [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] vs;
    logic signed [63:0]      wide;
    vs   = $signed(v);
    wide = 64'(vs);
    return wide[WORD_BITS-1:0];
  endfunction

endpackage

>>> hdl/deq_cell.sv
// One storage cell of the shifting deque row.
module deq_cell (
  input  logic                clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  deq_pkg::word_t      load_data,
  input  deq_pkg::word_t      prev_data,
  input  deq_pkg::word_t      next_data,
  output deq_pkg::word_t      data
);

  deq_pkg::word_t data_r;
  deq_pkg::word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.shift_up) begin
      data_nxt = prev_data;
    end else if (ctrl.shift_down) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> hdl/double_ended_queue_top.sv
// Top level of the double-ended queue: cell row, control and result register.
//
// The queue is a row of DEPTH cells with the front word always in cell 0
// and entries packed toward it, so cell i holds entry i while i < count.
// A push at the front shifts the whole row one cell toward the back and
// drops the new word into cell 0; a pop at the front shifts it toward the
// front. A push at the back loads the cell just past the last entry, and a
// pop at the back only lowers the count. A request first updates the row
// and the count, then its front and back words are picked into the result
// register once that register is free, and no new request is taken before
// its result is in that register; in_tready stays low while a request is
// in flight or its result cannot yet be handed on. A push on a full queue
// and a pop on an empty one leave the contents alone and report it in the
// status code. Result words of an empty queue read as zero.
module double_ended_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [7:0]  in_tuser,   // [2:0] action, [7:3] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] front_value, [63:32] back_value,
                                  // [68:64] count, [69] is_empty, [70] is_full,
                                  // [71] zero
  output logic [7:0]  out_tuser   // [1:0] status, [7:2] zero
);

  localparam int DEPTH = deq_pkg::DEPTH;
  localparam int CNT_W = deq_pkg::CNT_W;

  logic                           in_acc;
  logic                           out_free;
  logic [deq_pkg::ACT_W-1:0]      act;
  deq_pkg::word_t                 push_word;
  logic                           is_full_now;
  logic                           is_empty_now;

  logic                           busy_r;
  logic                           busy_nxt;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic [deq_pkg::STAT_W-1:0]     status_r;
  logic [deq_pkg::STAT_W-1:0]     status_nxt;

  logic                           out_tvalid_r;
  logic [71:0]                    out_tdata_r;
  logic [7:0]                     out_tuser_r;

  logic                           row_up;
  logic                           row_down;
  logic                           load_back;

  deq_pkg::word_t                 cell_data [DEPTH];
  deq_pkg::cell_ctrl_t            cell_ctrl [DEPTH];

  logic [deq_pkg::VAL_W-1:0]      front_word;
  logic [deq_pkg::VAL_W-1:0]      back_word;
  logic [deq_pkg::WORD_BITS-1:0]  back_sel [DEPTH];

  assign act          = in_tuser[deq_pkg::ACT_W-1:0];
  assign push_word    = deq_pkg::word_in(in_tdata);
  assign out_free     = !out_tvalid_r || out_tready;
  assign in_tready    = !busy_r;
  assign in_acc       = in_tvalid && in_tready;
  assign is_full_now  = (count_r == CNT_W'(DEPTH));
  assign is_empty_now = (count_r == '0);

  // Decode the request into row moves, new count and status.
  always_comb begin
    row_up     = 1'b0;
    row_down   = 1'b0;
    load_back  = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (in_acc) begin
      status_nxt = deq_pkg::STAT_OK;
      case (act)
        deq_pkg::ACT_PUSH_FRONT,
        deq_pkg::ACT_PUSH_BACK: begin
          if (is_full_now) begin
            status_nxt = deq_pkg::STAT_PUSH_FULL;
          end else begin
            row_up    = (act == deq_pkg::ACT_PUSH_FRONT);
            load_back = (act == deq_pkg::ACT_PUSH_BACK);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        deq_pkg::ACT_POP_FRONT,
        deq_pkg::ACT_POP_BACK: begin
          if (is_empty_now) begin
            status_nxt = deq_pkg::STAT_POP_EMPTY;
          end else begin
            row_down  = (act == deq_pkg::ACT_POP_FRONT);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          // none and unused codes: leave the queue as it is
        end
      endcase
    end
  end

  // Build the cell row; cell 0 is the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_pkg::word_t prev_w;
    deq_pkg::word_t next_w;

    if (i == 0) begin : g_first
      assign prev_w = push_word;
    end else begin : g_mid_prev
      assign prev_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_data[i+1];
    end

    assign cell_ctrl[i].shift_up   = row_up;
    assign cell_ctrl[i].shift_down = row_down;
    assign cell_ctrl[i].load       = load_back && (count_r == CNT_W'(i));

    // Mark the cell holding the back entry for the result select.
    assign back_sel[i] = (count_r == CNT_W'(i + 1)) ? cell_data[i] : '0;

    deq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .load_data (push_word),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i])
    );
  end

  // Merge the one-hot back select.
  always_comb begin
    deq_pkg::word_t acc;
    acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      acc = acc | back_sel[i];
    end
    back_word  = deq_pkg::word_out(acc);
    front_word = is_empty_now ? '0 : deq_pkg::word_out(cell_data[0]);
  end

  // Hold a request in flight until its result can enter the output register.
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (busy_r && out_free) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      status_r     <= deq_pkg::STAT_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (busy_r && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Capture the result; payload needs no reset.
  always_ff @(posedge clk) begin
    if (busy_r && out_free) begin
      out_tdata_r <= {1'b0, is_full_now, is_empty_now, count_r, back_word, front_word};
      out_tuser_r <= {6'd0, status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The count never passes the capacity.
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // An accepted request is in flight in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("request not held in flight");

  // A push that is not refused raises the count by one.
  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_full_now &&
     (act == deq_pkg::ACT_PUSH_FRONT || act == deq_pkg::ACT_PUSH_BACK))
    |=> count_r == CNT_W'($past(count_r) + CNT_W'(1)))
    else $error("push did not raise the count");

  // A result never reports empty and full at once.
  a_flags : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[69] && out_tdata_r[70]))
    else $error("result flags both empty and full");

endmodule
